[hw/rtl/lphs_pkg.sv]
// ============================================================================
// lphs_pkg
// Shared widths, operation codes, status codes and state type of the
// linear probing hash set.
// ============================================================================
package lphs_pkg;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 31;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } t_state;

endpackage

[hw/rtl/lphs_ram.sv]
// ============================================================================
// lphs_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
module lphs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/lphs_mod.sv]
// ============================================================================
// lphs_mod
// Home slot unit that reduces a value modulo the slot count with a
// reciprocal multiply, a remainder subtraction and a result register.
// ============================================================================
module lphs_mod #(
    parameter int SLOTS = 128
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lphs_pkg::VALUE_W-1:0] i_value,
    output logic                         o_done,
    output logic [$clog2(SLOTS)-1:0]     o_rem
);
    import lphs_pkg::*;

    localparam int AW      = $clog2(SLOTS);
    localparam int SHIFT   = VALUE_W + AW;
    localparam int RECIP_W = VALUE_W + 1;
    localparam int PW      = VALUE_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_FULL[RECIP_W-1:0];
    localparam logic [AW-1:0]      SLOTS_LO = AW'(SLOTS);

    logic               r_mul, n_mul;
    logic               r_sub, n_sub;
    logic               r_done, n_done;
    logic [VALUE_W-1:0] r_val, n_val;
    logic [AW-1:0]      r_quo, n_quo;
    logic [AW-1:0]      r_rem, n_rem;
    logic [PW-1:0]      prod;
    logic [AW-1:0]      quo_m;

    // The rounded-up reciprocal gives the exact quotient for every value
    // width input; only its low bits are needed for the remainder.
    assign prod  = PW'(r_val) * PW'(RECIP);
    assign quo_m = r_quo * SLOTS_LO;

    always_comb begin
        n_mul  = i_start;
        n_sub  = r_mul;
        n_done = r_sub;
        n_val  = i_start ? i_value : r_val;
        n_quo  = r_mul ? prod[SHIFT +: AW] : r_quo;
        n_rem  = r_sub ? (r_val[AW-1:0] - quo_m) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_sub  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= n_mul;
            r_sub  <= n_sub;
            r_done <= n_done;
        end
        r_val <= n_val;
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[hw/rtl/linear_probe_hash_set.sv]
// ============================================================================
// linear_probe_hash_set
// Open-addressing hash set with linear probing. Slot contents and valid bits
// live in one RAM; a sequencer reads one slot per cycle and writes back at most once.
// ============================================================================
//
// Channel   Direction  Handshake             Fields
// command   in         start && !busy        i_func, i_item_value
// result    out        o_valid (one cycle)   o_slot_index, o_status
//
// An operation first reduces the value to its home slot with a reciprocal
// multiply, then probes k slots (1 to SLOTS) from the home slot, one probe
// per cycle through the single read port, behind the registered RAM read.
// An unused operation code gives its result beat once the reduction is done,
// without probing. After reset, a clearing pass writes every slot empty while
// busy is high. The receiver cannot stall; each result is shown for one cycle.
//
module linear_probe_hash_set #(
    parameter int SLOTS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lphs_pkg::FUNC_W-1:0]   i_func,
    input  logic [lphs_pkg::VALUE_W-1:0]  i_item_value,
    output logic                          o_valid,
    output logic [lphs_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [lphs_pkg::STATUS_W-1:0] o_status
);
    import lphs_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = VALUE_W + 1;

    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic [AW-1:0]       r_addr, n_addr;
    logic [AW-1:0]       r_chk_addr, n_chk_addr;
    logic                r_pend, n_pend;
    logic [CW-1:0]       r_issued, n_issued;
    logic [CW-1:0]       r_left, n_left;
    logic                r_valid, n_valid;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    t_status             r_status, n_status;

    logic                accept;
    logic                mod_done;
    logic [AW-1:0]       mod_rem;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [MW-1:0]       mem_wdata;
    logic                mem_re;
    logic [MW-1:0]       mem_rdata;
    logic                rd_valid;
    logic [VALUE_W-1:0]  rd_value;
    logic                op_known;
    logic                hit;
    logic                lap_end;
    logic [AW-1:0]       addr_next;
    logic [SLOT_W+AW-1:0] slot_ext;

    assign accept    = start && (r_state == S_IDLE);
    assign rd_valid  = mem_rdata[VALUE_W];
    assign rd_value  = mem_rdata[VALUE_W-1:0];
    assign op_known  = (r_func == OP_INSERT) || (r_func == OP_SEARCH) ||
                       (r_func == OP_REMOVE);
    assign hit       = (r_func == OP_INSERT) ? !rd_valid
                                             : (rd_valid && (rd_value == r_value));
    assign lap_end   = (r_left == CW'(1));
    assign addr_next = (r_addr == AW'(SLOTS - 1)) ? '0 : (r_addr + 1'b1);
    assign slot_ext  = {{SLOT_W{1'b0}}, r_chk_addr};

    lphs_mod #(
        .SLOTS (SLOTS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_value (i_item_value),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    lphs_ram #(
        .WIDTH (MW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == AW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    n_state = op_known ? S_PROBE : S_IDLE;
                end
            end
            S_PROBE: begin
                if (r_pend && (hit || lap_end)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_func     = r_func;
        n_value    = r_value;
        n_addr     = r_addr;
        n_chk_addr = r_chk_addr;
        n_pend     = 1'b0;
        n_issued   = r_issued;
        n_left     = r_left;
        n_valid    = 1'b0;
        n_slot     = r_slot;
        n_status   = r_status;
        mem_we     = 1'b0;
        mem_waddr  = r_addr;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_addr = addr_next;
            end
            S_IDLE: begin
                if (start) begin
                    n_func  = i_func;
                    n_value = i_item_value;
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    n_addr   = mod_rem;
                    n_issued = '0;
                    n_left   = CW'(SLOTS);
                    if (!op_known) begin
                        n_valid  = 1'b1;
                        n_slot   = '0;
                        n_status = ST_NOT_FOUND;
                    end
                end
            end
            S_PROBE: begin
                if (r_issued != CW'(SLOTS)) begin
                    mem_re     = 1'b1;
                    n_addr     = addr_next;
                    n_chk_addr = r_addr;
                    n_issued   = r_issued + 1'b1;
                    n_pend     = 1'b1;
                end
                if (r_pend) begin
                    if (hit) begin
                        n_pend    = 1'b0;
                        n_valid   = 1'b1;
                        n_slot    = slot_ext[SLOT_W-1:0];
                        n_status  = ST_OK;
                        mem_waddr = r_chk_addr;
                        if (r_func == OP_INSERT) begin
                            mem_we    = 1'b1;
                            mem_wdata = {1'b1, r_value};
                        end else if (r_func == OP_REMOVE) begin
                            mem_we    = 1'b1;
                            mem_wdata = {1'b0, rd_value};
                        end
                    end else if (lap_end) begin
                        n_pend   = 1'b0;
                        n_valid  = 1'b1;
                        n_slot   = '0;
                        n_status = (r_func == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    end else begin
                        n_left = r_left - 1'b1;
                    end
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_func     <= n_func;
        r_value    <= n_value;
        r_chk_addr <= n_chk_addr;
        r_issued   <= n_issued;
        r_left     <= n_left;
        r_slot     <= n_slot;
        r_status   <= n_status;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_slot_index = r_slot;
    assign o_status     = r_status;

endmodule

[hw/rtl/lphs_check.sv]
// ============================================================================
// lphs_check
// Port-level checks of the linear probing hash set, bound to the top level.
// ============================================================================
module lphs_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [lphs_pkg::SLOT_W-1:0]   o_slot_index,
    input logic [lphs_pkg::STATUS_W-1:0] o_status
);
    import lphs_pkg::*;

    // An accepted command keeps the block busy until its result.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a command");

    // A result beat only appears once the block has returned to idle.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    // Each operation passes through the reduction before its result, so result beats never come back to back.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result beats in a row");

    // Failed operations report slot zero.
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_slot_index == '0))
        else $error("nonzero slot on a failed operation");

endmodule

bind linear_probe_hash_set lphs_check u_lphs_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_slot_index (o_slot_index),
    .o_status     (o_status)
);

[bench/tb_linear_probe_hash_set.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_linear_probe_hash_set
// Self-checking bench for the linear probing hash set. A short directed
// table covers the empty table, wrap-around, duplicates and the unused code.
// Random phases then fill, churn and drain the table with clustered values.
// Each result beat is checked against a behavioral slot model or typed row.
// ============================================================================
module tb_linear_probe_hash_set;
    import lphs_pkg::*;

    localparam int SLOTS_N = 128;
    localparam int RANDOM_CMDS = 1100;
    localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [SLOT_W-1:0]  slot;
        t_status            status;
    } t_dir_row;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_hash_result;

    typedef enum int {
        PH_FILL,
        PH_CHURN,
        PH_DRAIN
    } t_phase;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   i_func;
    logic [VALUE_W-1:0]  i_item_value;
    logic                o_valid;
    logic [SLOT_W-1:0]   o_slot_index;
    logic [STATUS_W-1:0] o_status;

    logic [VALUE_W-1:0] stored_val [SLOTS_N];
    logic               held [SLOTS_N];
    t_hash_result       pending_results [$];

    int  errors;
    int  cmd_count [4];
    int  ok_seen;
    int  miss_seen;
    int  full_seen;
    bit  no_gaps;
    int  cluster_base;

    t_dir_row dir_rows [21] = '{
        '{OP_SEARCH, 31'h0000_0000, 1'b1, 7'd0,   ST_NOT_FOUND},
        '{OP_REMOVE, 31'h7FFF_FFFF, 1'b1, 7'd0,   ST_NOT_FOUND},
        '{OP_UNUSED, 31'h0000_0005, 1'b1, 7'd0,   ST_NOT_FOUND},
        '{OP_INSERT, 31'h0000_0000, 1'b1, 7'd0,   ST_OK},
        '{OP_INSERT, 31'h7FFF_FFFF, 1'b1, 7'd127, ST_OK},
        '{OP_INSERT, 31'h7FFF_FF7F, 1'b0, 7'd0,   ST_OK},
        '{OP_INSERT, 31'h0000_0080, 1'b0, 7'd0,   ST_OK},
        '{OP_INSERT, 31'h0000_0000, 1'b0, 7'd0,   ST_OK},
        '{OP_SEARCH, 31'h0000_0000, 1'b1, 7'd0,   ST_OK},
        '{OP_REMOVE, 31'h0000_0000, 1'b1, 7'd0,   ST_OK},
        '{OP_SEARCH, 31'h0000_0000, 1'b0, 7'd0,   ST_OK},
        '{OP_SEARCH, 31'h7FFF_FF7F, 1'b0, 7'd0,   ST_OK},
        '{OP_REMOVE, 31'h7FFF_FF7F, 1'b0, 7'd0,   ST_OK},
        '{OP_SEARCH, 31'h7FFF_FF7F, 1'b0, 7'd0,   ST_OK},
        '{OP_INSERT, 31'h2AAA_AAAA, 1'b0, 7'd0,   ST_OK},
        '{OP_INSERT, 31'h5555_5555, 1'b0, 7'd0,   ST_OK},
        '{OP_SEARCH, 31'h5555_5555, 1'b0, 7'd0,   ST_OK},
        '{OP_REMOVE, 31'h2AAA_AAAA, 1'b0, 7'd0,   ST_OK},
        '{OP_UNUSED, 31'h7FFF_FFFF, 1'b1, 7'd0,   ST_NOT_FOUND},
        '{OP_REMOVE, 31'h7FFF_FFFF, 1'b1, 7'd127, ST_OK},
        '{OP_SEARCH, 31'h7FFF_FFFF, 1'b1, 7'd0,   ST_NOT_FOUND}
    };

    linear_probe_hash_set #(
        .SLOTS(SLOTS_N)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_item_value (i_item_value),
        .o_valid      (o_valid),
        .o_slot_index (o_slot_index),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("linear_probe_hash_set regression: fail");
        $finish;
    end

    // Walks the probe path from the home slot for one lap and applies the operation.
    function automatic void apply_hash_op(input logic [FUNC_W-1:0] f,
                                          input logic [VALUE_W-1:0] v,
                                          output t_hash_result res);
        int s;
        int n;
        int hit;
        hit = -1;
        s = int'(v % SLOTS_N);
        for (n = 0; n < SLOTS_N; n++) begin
            if (hit < 0) begin
                if (f == OP_INSERT && !held[s]) begin
                    hit = s;
                end else if ((f == OP_SEARCH || f == OP_REMOVE) && held[s]
                             && stored_val[s] == v) begin
                    hit = s;
                end
            end
            s = (s + 1) % SLOTS_N;
        end
        res.status = ST_NOT_FOUND;
        if (f == OP_INSERT) begin
            if (hit >= 0) begin
                stored_val[hit] = v;
                held[hit] = 1'b1;
                res.status = ST_OK;
            end else begin
                res.status = ST_FULL;
            end
        end else if (f == OP_SEARCH || f == OP_REMOVE) begin
            if (hit >= 0) begin
                res.status = ST_OK;
                if (f == OP_REMOVE) begin
                    held[hit] = 1'b0;
                end
            end
        end
        res.slot = (res.status == ST_OK) ? hit[SLOT_W-1:0] : '0;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [31:0] r;
        r = $urandom();
        return r[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] clustered_value();
        logic [31:0] r;
        int home;
        r = $urandom();
        home = (cluster_base + $urandom_range(0, 11)) % SLOTS_N;
        return {r[VALUE_W-1:SLOT_W], home[SLOT_W-1:0]};
    endfunction

    function automatic logic [VALUE_W-1:0] stored_value_pick();
        int idx [$];
        int i;
        for (i = 0; i < SLOTS_N; i++) begin
            if (held[i]) begin
                idx.push_back(i);
            end
        end
        if (idx.size() == 0) begin
            return clustered_value();
        end
        return stored_val[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v,
                            input logic typed, input logic [SLOT_W-1:0] t_slot,
                            input t_status t_st);
        int gap;
        t_hash_result res;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 99) < 33) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 170)
                                              : $urandom_range(1, 8);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_func       <= f;
        i_item_value <= v;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        apply_hash_op(f, v, res);
        if (typed) begin
            res.slot = t_slot;
            res.status = t_st;
        end
        pending_results.push_back(res);
        cmd_count[f]++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_hash_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, slot_index %0d status %0d",
                         $time, o_slot_index, o_status);
            end else begin
                want = pending_results.pop_front();
                if (o_slot_index !== want.slot) begin
                    errors++;
                    $display("%0t: slot_index expected %0d, got %0d",
                             $time, want.slot, o_slot_index);
                end
                if (o_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, o_status);
                end
                case (want.status)
                    ST_OK:        ok_seen++;
                    ST_FULL:      full_seen++;
                    default:      miss_seen++;
                endcase
            end
        end
    end

    initial begin : stimulus
        int i;
        int sent;
        int phase_no;
        int phase_len;
        int roll;
        int ins_pct;
        int srch_pct;
        int rem_pct;
        t_phase kind;
        logic [FUNC_W-1:0] f;
        logic [VALUE_W-1:0] v;

        errors = 0;
        ok_seen = 0;
        miss_seen = 0;
        full_seen = 0;
        no_gaps = 1'b0;
        cluster_base = 0;
        for (i = 0; i < 4; i++) begin
            cmd_count[i] = 0;
        end
        for (i = 0; i < SLOTS_N; i++) begin
            held[i] = 1'b0;
            stored_val[i] = '0;
        end
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_func       <= OP_INSERT;
        i_item_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < $size(dir_rows); i++) begin
            send_cmd(dir_rows[i].func, dir_rows[i].value, dir_rows[i].typed,
                     dir_rows[i].slot, dir_rows[i].status);
        end
        drain_results();

        // The first phase fills the table so that inserts into a full table occur.
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_CMDS) begin
            kind = (phase_no == 0) ? PH_FILL : t_phase'($urandom_range(0, 2));
            no_gaps = (phase_no == 1);
            cluster_base = $urandom_range(0, SLOTS_N - 1);
            phase_len = (kind == PH_FILL) ? $urandom_range(180, 240)
                                          : $urandom_range(100, 200);
            case (kind)
                PH_FILL:  begin ins_pct = 85; srch_pct = 8;  rem_pct = 4;  end
                PH_CHURN: begin ins_pct = 40; srch_pct = 30; rem_pct = 20; end
                default:  begin ins_pct = 10; srch_pct = 15; rem_pct = 65; end
            endcase
            for (i = 0; i < phase_len && sent < RANDOM_CMDS; i++) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_pct) begin
                    f = OP_INSERT;
                    roll = $urandom_range(0, 99);
                    v = (roll < 70) ? clustered_value()
                      : (roll < 85) ? stored_value_pick() : random_value();
                end else if (roll < ins_pct + srch_pct) begin
                    f = OP_SEARCH;
                    v = stored_value_pick();
                end else if (roll < ins_pct + srch_pct + rem_pct) begin
                    f = OP_REMOVE;
                    v = stored_value_pick();
                end else begin
                    roll = $urandom_range(0, 3);
                    f = (roll == 0) ? OP_UNUSED : (roll == 1) ? OP_SEARCH
                      : (roll == 2) ? OP_REMOVE : OP_INSERT;
                    v = random_value();
                end
                send_cmd(f, v, 1'b0, '0, ST_OK);
                sent++;
            end
            drain_results();
            phase_no++;
        end

        start <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);

        $display("Commands: %0d insert, %0d search, %0d remove, %0d unused code.",
                 cmd_count[OP_INSERT], cmd_count[OP_SEARCH], cmd_count[OP_REMOVE],
                 cmd_count[OP_UNUSED]);
        $display("Results: %0d ok, %0d not found, %0d table full, over %0d phases.",
                 ok_seen, miss_seen, full_seen, phase_no);
        if (errors == 0) begin
            $display("linear_probe_hash_set regression: pass");
        end else begin
            $display("linear_probe_hash_set regression: fail");
        end
        $finish;
    end

endmodule
